[src/hls_pkg.sv]
// Shared types and constants for the header line splitter.
package hls_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int OUT_BITS    = 16;

   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef logic [OFFSET_BITS-1:0] offset_type;

   typedef enum logic [2:0] {
      PH_SKIP    = 3'd0,
      PH_COMMENT = 3'd1,
      PH_FIELD   = 3'd2,
      PH_BLANKS  = 3'd3,
      PH_VALUE   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic                line_found;
      logic [OUT_BITS-1:0] field_start;
      logic [OUT_BITS-1:0] field_length;
      logic [OUT_BITS-1:0] value_start;
      logic [OUT_BITS-1:0] value_length;
      logic                end_of_buffer;
   } rsp_payload_type;

endpackage

[src/header_line_splitter_core.sv]
// Header line splitter: byte-serial "field: value" line scanner with buffered results.
//
// Takes one header byte per cycle while req_ready is high and reports each
// "field: value" line, as offsets and lengths, when its CR or LF arrives; a
// byte flagged last_byte also yields a result with end_of_buffer set and
// returns the scanner to offset zero. Scan phase and offset registers update on the
// accepting edge; a result is registered in rsp_ff, or in skid_ff while the
// head waits. Results pass through a two-entry output buffer, so req_ready
// stays high while one result waits; it drops only when both entries are full.
// There is no start-up pass after reset. Offsets saturate at 2**OFFSET_BITS-1.
module header_line_splitter_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hls_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hls_pkg::rsp_payload_type rsp_payload
);
   import hls_pkg::*;

   localparam offset_type OFFSET_MAX = '1;

   phase_type       phase_ff, phase_in;
   offset_type      offset_ff, offset_in;
   offset_type      field_begin_ff, field_begin_in;
   offset_type      field_size_ff, field_size_in;
   offset_type      value_begin_ff, value_begin_in;

   rsp_payload_type rsp_ff, skid_ff, result;
   logic            rsp_valid_ff, skid_valid_ff;

   logic            req_fire, rsp_pop, push;
   logic            is_alnum, is_eol, is_blank, found;
   logic [7:0]      ch;
   offset_type      vlen;

   assign ch       = req_payload.data_byte;
   assign req_fire = req_valid && req_ready;
   assign rsp_pop  = rsp_valid_ff && rsp_ready;

   assign is_alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                     (ch >= 8'h61 && ch <= 8'h7A);
   assign is_eol   = (ch == CHAR_LF) || (ch == CHAR_CR);
   assign is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB);

   // next scan phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_SKIP: begin
            if (ch == CHAR_HASH) phase_in = PH_COMMENT;
            else if (is_alnum)   phase_in = PH_FIELD;
         end
         PH_COMMENT: begin
            if (is_eol) phase_in = PH_SKIP;
         end
         PH_FIELD: begin
            if (ch == CHAR_COLON) phase_in = PH_BLANKS;
            else if (is_eol)      phase_in = PH_SKIP;
         end
         PH_BLANKS: begin
            if (!is_blank) phase_in = is_eol ? PH_SKIP : PH_VALUE;
         end
         PH_VALUE: begin
            if (is_eol) phase_in = PH_SKIP;
         end
         default: phase_in = PH_SKIP;
      endcase
      if (req_payload.last_byte) phase_in = PH_SKIP;
   end

   // position registers and result
   always_comb begin
      field_begin_in = field_begin_ff;
      field_size_in  = field_size_ff;
      value_begin_in = value_begin_ff;
      found          = 1'b0;
      vlen           = '0;
      case (phase_ff)
         PH_SKIP: begin
            if (ch != CHAR_HASH && is_alnum) field_begin_in = offset_ff;
         end
         PH_FIELD: begin
            if (ch == CHAR_COLON) field_size_in = offset_ff - field_begin_ff;
         end
         PH_BLANKS: begin
            if (!is_blank) begin
               value_begin_in = offset_ff;
               found          = is_eol;
            end
         end
         PH_VALUE: begin
            if (is_eol) begin
               found = 1'b1;
               vlen  = offset_ff - value_begin_ff;
            end
         end
         default: ;
      endcase

      offset_in = (offset_ff != OFFSET_MAX) ? offset_ff + 1'b1 : offset_ff;

      result.line_found    = found;
      result.field_start   = found ? OUT_BITS'(field_begin_in) : '0;
      result.field_length  = found ? OUT_BITS'(field_size_in) : '0;
      result.value_start   = found ? OUT_BITS'(value_begin_in) : '0;
      result.value_length  = found ? OUT_BITS'(vlen) : '0;
      result.end_of_buffer = req_payload.last_byte;

      // last byte returns everything to reset values
      if (req_payload.last_byte) begin
         offset_in      = '0;
         field_begin_in = '0;
         field_size_in  = '0;
         value_begin_in = '0;
      end
   end

   assign push = req_fire && (found || req_payload.last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SKIP;
         offset_ff      <= '0;
         field_begin_ff <= '0;
         field_size_ff  <= '0;
         value_begin_ff <= '0;
      end else if (req_fire) begin
         phase_ff       <= phase_in;
         offset_ff      <= offset_in;
         field_begin_ff <= field_begin_in;
         field_size_ff  <= field_size_in;
         value_begin_ff <= value_begin_in;
      end
   end

   // two-entry output buffer: rsp_ff is the head, skid_ff holds the overflow item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || rsp_pop) begin
            rsp_ff       <= result;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_ready   = !skid_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a head item");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.last_byte |=> phase_ff == PH_SKIP && offset_ff == '0)
      else $error("state not cleared after last byte");

   a_offset_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_payload.last_byte && offset_ff != OFFSET_MAX
      |=> offset_ff == $past(offset_ff) + 1'b1)
      else $error("byte offset did not advance");

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.line_found
      |-> rsp_ff.end_of_buffer && rsp_ff.field_start == '0 && rsp_ff.field_length == '0
          && rsp_ff.value_start == '0 && rsp_ff.value_length == '0)
      else $error("result without a line carries nonzero fields");

endmodule

[verif/header_line_monitor.sv]
`timescale 1ns / 100ps
// Monitor for the header line splitter: predicts each result and checks it on the rsp_ channel.
module header_line_monitor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  hls_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  hls_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       results_waiting,
   output int                       lines_seen,
   output int                       buffers_seen
);
   import hls_pkg::*;

   phase_type       phase;
   offset_type      cur_offset;
   offset_type      field_begin;
   offset_type      field_size;
   offset_type      value_begin;
   rsp_payload_type expected_lines[$];
   int              mismatches   = 0;
   int              line_total   = 0;
   int              buffer_total = 0;

   function automatic bit is_line_end(input logic [7:0] ch);
      return ch == CHAR_CR || ch == CHAR_LF;
   endfunction

   task automatic clear_scan();
      phase       = PH_SKIP;
      cur_offset  = '0;
      field_begin = '0;
      field_size  = '0;
      value_begin = '0;
   endtask

   // Advance the scanner by one byte and queue the result it causes, if any.
   task automatic scan_byte(input logic [7:0] ch, input logic closing);
      rsp_payload_type res;
      offset_type      here;
      offset_type      value_size;
      logic            found;
      here       = cur_offset;
      value_size = '0;
      found      = 1'b0;
      case (phase)
         PH_SKIP: begin
            if (ch == CHAR_HASH) begin
               phase = PH_COMMENT;
            end else if ((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
                         (ch >= "a" && ch <= "z")) begin
               field_begin = here;
               phase       = PH_FIELD;
            end
         end
         PH_COMMENT: begin
            if (is_line_end(ch)) phase = PH_SKIP;
         end
         PH_FIELD: begin
            if (ch == CHAR_COLON) begin
               field_size = here - field_begin;
               phase      = PH_BLANKS;
            end else if (is_line_end(ch)) begin
               phase = PH_SKIP;
            end
         end
         PH_BLANKS: begin
            if (ch != CHAR_SPACE && ch != CHAR_TAB) begin
               value_begin = here;
               if (is_line_end(ch)) begin
                  found = 1'b1;
                  phase = PH_SKIP;
               end else begin
                  phase = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            if (is_line_end(ch)) begin
               found      = 1'b1;
               value_size = here - value_begin;
               phase      = PH_SKIP;
            end
         end
         default: begin
            phase = PH_SKIP;
         end
      endcase

      // hold the offset once it saturates
      if (cur_offset != '1) cur_offset = cur_offset + 1'b1;

      if (found || closing) begin
         res = '0;
         res.line_found    = found;
         res.end_of_buffer = closing;
         if (found) begin
            res.field_start  = field_begin;
            res.field_length = field_size;
            res.value_start  = value_begin;
            res.value_length = value_size;
         end
         expected_lines.push_back(res);
      end
      if (closing) clear_scan();
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (got.line_found) line_total++;
      if (got.end_of_buffer) buffer_total++;
      if (expected_lines.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result with none expected: found=%0b field=%0d+%0d value=%0d+%0d end=%0b",
                     got.line_found, got.field_start, got.field_length,
                     got.value_start, got.value_length, got.end_of_buffer);
         return;
      end
      want = expected_lines.pop_front();
      if (got.line_found   !== want.line_found   || got.field_start   !== want.field_start  ||
          got.field_length !== want.field_length || got.value_start   !== want.value_start  ||
          got.value_length !== want.value_length || got.end_of_buffer !== want.end_of_buffer) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: at %0t expected found=%0b field=%0d+%0d value=%0d+%0d end=%0b",
                     $realtime, want.line_found, want.field_start, want.field_length,
                     want.value_start, want.value_length, want.end_of_buffer);
            $display("       actual          found=%0b field=%0d+%0d value=%0d+%0d end=%0b",
                     got.line_found, got.field_start, got.field_length,
                     got.value_start, got.value_length, got.end_of_buffer);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         expected_lines.delete();
      end else begin
         // take the input first so a same-edge result still finds its expectation
         if (req_valid && req_ready) scan_byte(req_payload.data_byte, req_payload.last_byte);
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
      end
      error_count     <= mismatches;
      results_waiting <= expected_lines.size();
      lines_seen      <= line_total;
      buffers_seen    <= buffer_total;
   end

endmodule

[verif/tb_header_line_splitter_core.sv]
`timescale 1ns / 100ps
// Testbench top for the header line splitter: stimulus, handshake pacing and verdict.
module tb_header_line_splitter_core;
   import hls_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   int error_count;
   int results_waiting;
   int lines_seen;
   int buffers_seen;
   int bytes_sent = 0;
   bit sender_eager = 1'b0;

   header_line_splitter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   header_line_monitor u_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .error_count     (error_count),
      .results_waiting (results_waiting),
      .lines_seen      (lines_seen),
      .buffers_seen    (buffers_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] pick_word_char();
      int idx;
      idx = $urandom_range(0, 61);
      if (idx < 10) return "0" + 8'(idx);
      if (idx < 36) return "A" + 8'(idx - 10);
      return "a" + 8'(idx - 36);
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch == CHAR_CR || ch == CHAR_LF);
      return ch;
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic closing);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload.data_byte <= value;
      req_payload.last_byte <= closing;
      req_valid             <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string text, input bit closing);
      foreach (text[i]) send_byte(text[i], closing && i == text.len() - 1);
   endtask

   // Drop valid and hold off until every queued result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   // Build one buffer of random lines, mostly well formed, and send it.
   task automatic send_random_buffer();
      logic [7:0] frame[$];
      int         kind;
      repeat ($urandom_range(1, 6)) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            repeat ($urandom_range(0, 2))
               frame.push_back($urandom_range(0, 1) ? CHAR_SPACE :
                               8'(8'h80 + $urandom_range(0, 127)));
            frame.push_back(pick_word_char());
            repeat ($urandom_range(0, 5))
               frame.push_back($urandom_range(0, 7) == 0 ? pick_text_char() : pick_word_char());
            frame.push_back(CHAR_COLON);
            repeat ($urandom_range(0, 3))
               frame.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            repeat ($urandom_range(0, 8)) frame.push_back(pick_text_char());
            case ($urandom_range(0, 2))
               0: frame.push_back(CHAR_CR);
               1: frame.push_back(CHAR_LF);
               default: begin
                  frame.push_back(CHAR_CR);
                  frame.push_back(CHAR_LF);
               end
            endcase
         end else if (kind == 6) begin
            frame.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 6)) frame.push_back(pick_text_char());
            frame.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 7)) frame.push_back(pick_word_char());
            frame.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
         end else begin
            repeat ($urandom_range(1, 5)) frame.push_back(8'($urandom_range(0, 255)));
         end
      end
      // cut some buffers short so the last line is left open
      if ($urandom_range(0, 3) == 0)
         while (frame.size() > 1 && $urandom_range(0, 2) != 0) void'(frame.pop_back());
      sender_eager = ($urandom_range(0, 3) == 0);
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   initial begin : receiver
      bit eager;
      int stall;
      eager = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) eager = !eager;
         stall = eager ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int random_start;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_ready   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // extremes, comments, blanks, empty value, dropped and open lines
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_text("#A\naZ: \tv\r9:\n", 1'b1);
      send_text("x\nq:w", 1'b1);
      send_byte(8'h00, 1'b1);
      send_text("#", 1'b1);
      send_text("k: ", 1'b1);
      wait_for_results();

      random_start = bytes_sent;
      while (bytes_sent - random_start < 700) send_random_buffer();
      wait_for_results();
      repeat (20) @(posedge clock);

      $display("Summary: %0d bytes in %0d buffers, %0d lines reported,", bytes_sent,
               buffers_seen, lines_seen);
      $display("  with random stalls on both sides, comments, dropped and open lines.");
      if (error_count == 0 && results_waiting == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[header_line_splitter_core.f]
src/hls_pkg.sv
src/header_line_splitter_core.sv
verif/header_line_monitor.sv
verif/tb_header_line_splitter_core.sv
